>>> sv/clsr_pkg.sv
package clsr_pkg;

    // Value width of both generators, the table and the output word
    localparam int unsigned VAL_W  = 31;
    localparam int unsigned MUL_W  = 16;
    localparam int unsigned TAIL_W = 8;
    localparam int unsigned PROD_W = VAL_W + MUL_W;

    // Moduli, multipliers and the folding tails 2^31 - modulus
    localparam logic [VAL_W-1:0]  MOD1  = 31'd2147483563;
    localparam logic [VAL_W-1:0]  MOD2  = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL1  = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL2  = 16'd40692;
    localparam logic [TAIL_W-1:0] TAIL1 = 8'd85;
    localparam logic [TAIL_W-1:0] TAIL2 = 8'd249;

    // Largest output value, MOD1 - 1
    localparam logic [VAL_W-1:0] MAXOUT = 31'd2147483562;

    // Reset values of the generators
    localparam logic [VAL_W-1:0] SEED1_INIT = 31'd1;
    localparam logic [VAL_W-1:0] SEED2_INIT = 31'd123456789;

    // Shuffle table depth and number of warm-up steps ahead of the fill
    localparam int unsigned TABLE_DEPTH_DEF = 32;
    localparam int unsigned WARMUP          = 8;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic seed_load;    // load both generators from the seed, arm the step counter
        logic mul_start;    // capture both generator products
        logic seed_update;  // write back generator 1, fill the table, count down
        logic draw_read;    // read the table slot picked by the last output
        logic gen_update;   // write back both generators
        logic draw_finish;  // combine, refill the slot, load the output word
    } t_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic cnt_zero;     // last reseed step
        logic out_free;     // output register can take a word this cycle
    } t_stat;

endpackage

>>> sv/clsr_ctrl.sv
module clsr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_action,
    input  clsr_pkg::t_stat i_stat,
    output logic           o_ready,
    output clsr_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SMUL = 6'b000010,
        S_SUPD = 6'b000100,
        S_DRD  = 6'b001000,
        S_DMUL = 6'b010000,
        S_DFIN = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take a word only while idle
    assign o_ready = (r_state == S_IDLE);

    // Sequence reseed steps and draws
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action) begin
                        o_cmd.seed_load = 1'b1;
                        n_state         = S_SMUL;
                    end else begin
                        o_cmd.draw_read = 1'b1;
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_DMUL;
                    end
                end
            end
            S_SMUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_SUPD;
            end
            S_SUPD: begin
                o_cmd.seed_update = 1'b1;
                n_state           = i_stat.cnt_zero ? S_DRD : S_SMUL;
            end
            S_DRD: begin
                o_cmd.draw_read = 1'b1;
                o_cmd.mul_start = 1'b1;
                n_state         = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.gen_update = 1'b1;
                n_state          = S_DFIN;
            end
            S_DFIN: begin
                // Hold until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.draw_finish = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/clsr_datapath.sv
module clsr_datapath #(
    parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  clsr_pkg::t_cmd             i_cmd,
    output clsr_pkg::t_stat            o_stat,
    input  logic [clsr_pkg::VAL_W-1:0] i_seed,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [clsr_pkg::VAL_W-1:0] o_out_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + clsr_pkg::WARMUP);
    localparam int unsigned NDIV_I = 1 + 32'(clsr_pkg::MAXOUT) / TABLE_DEPTH;
    localparam logic [31:0] NDIV = 32'(NDIV_I);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + clsr_pkg::WARMUP - 1);
    localparam logic [CNT_W-1:0] CNT_FILL = CNT_W'(TABLE_DEPTH);

    // Reduce a product modulo 2^31 - tail: fold the high part, then one subtract
    function automatic logic [clsr_pkg::VAL_W-1:0] fold_mod(
        input logic [clsr_pkg::PROD_W-1:0] p,
        input logic [clsr_pkg::TAIL_W-1:0] tail,
        input logic [clsr_pkg::VAL_W-1:0]  m
    );
        logic [23:0] hi_t;
        logic [31:0] s;
        hi_t = {8'd0, p[46:31]} * {16'd0, tail};
        s    = {1'b0, p[30:0]} + {8'd0, hi_t};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[30:0];
    endfunction

    logic [clsr_pkg::VAL_W-1:0]  r_g1;
    logic [clsr_pkg::VAL_W-1:0]  r_g2;
    logic [clsr_pkg::VAL_W-1:0]  r_last;
    logic [clsr_pkg::PROD_W-1:0] r_p1;
    logic [clsr_pkg::PROD_W-1:0] r_p2;
    logic [CNT_W-1:0]            r_cnt;
    logic [IDX_W-1:0]            r_slot;
    logic [clsr_pkg::VAL_W-1:0]  r_rd_raw;
    logic                        r_rd_vld;
    logic [TABLE_DEPTH-1:0]      r_tab_vld;
    logic                        r_out_valid;
    logic [clsr_pkg::VAL_W-1:0]  r_out;

    logic [clsr_pkg::VAL_W-1:0]  mem [TABLE_DEPTH];

    logic [clsr_pkg::VAL_W-1:0]  seed_eff;
    logic [clsr_pkg::VAL_W-1:0]  res1;
    logic [clsr_pkg::VAL_W-1:0]  res2;
    logic [IDX_W-1:0]            slot_sel;
    logic [clsr_pkg::VAL_W-1:0]  rd_data;
    logic [31:0]                 diff;
    logic                        fill;
    logic                        mem_we;
    logic [IDX_W-1:0]            mem_addr;
    logic [clsr_pkg::VAL_W-1:0]  mem_wdata;

    // Map a zero seed to one
    assign seed_eff = (i_seed == '0) ? 31'd1 : i_seed;

    // Second half of both modular multiplies
    assign res1 = fold_mod(r_p1, clsr_pkg::TAIL1, clsr_pkg::MOD1);
    assign res2 = fold_mod(r_p2, clsr_pkg::TAIL2, clsr_pkg::MOD2);

    // Pick the slot: count the bucket bounds at or below the last output
    always_comb begin
        slot_sel = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({1'b0, r_last} >= 32'(k) * NDIV) begin
                slot_sel = IDX_W'(k);
            end
        end
    end

    // Never-written slots read as zero
    assign rd_data = r_rd_vld ? r_rd_raw : '0;

    // Combine slot and generator 2, wrap non-positive results into range
    always_comb begin
        diff = {1'b0, rd_data} - {1'b0, r_g2};
        if (diff[31] || (diff == '0)) begin
            diff = diff + {1'b0, clsr_pkg::MAXOUT};
        end
    end

    assign fill      = (r_cnt < CNT_FILL);
    assign mem_we    = (i_cmd.seed_update && fill) || i_cmd.draw_finish;
    assign mem_addr  = i_cmd.draw_finish ? r_slot : r_cnt[IDX_W-1:0];
    assign mem_wdata = i_cmd.draw_finish ? r_g1 : res1;

    // Generator products, first half of the multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_p1 <= {16'd0, r_g1} * {31'd0, clsr_pkg::MUL1};
            r_p2 <= {16'd0, r_g2} * {31'd0, clsr_pkg::MUL2};
        end
    end

    // Generator, last output and step counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1   <= clsr_pkg::SEED1_INIT;
            r_g2   <= clsr_pkg::SEED2_INIT;
            r_last <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.seed_load) begin
                r_g1  <= seed_eff;
                r_g2  <= seed_eff;
                r_cnt <= CNT_START;
            end
            if (i_cmd.seed_update) begin
                r_g1 <= res1;
                if (r_cnt == '0) begin
                    r_last <= res1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            if (i_cmd.gen_update) begin
                r_g1 <= res1;
                r_g2 <= res2;
            end
            if (i_cmd.draw_finish) begin
                r_last <= diff[30:0];
            end
        end
    end

    // Shuffle table storage with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (i_cmd.draw_read) begin
            r_rd_raw <= mem[slot_sel];
            r_slot   <= slot_sel;
        end
    end

    // Per-slot valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (mem_we) begin
                r_tab_vld[mem_addr] <= 1'b1;
            end
            if (i_cmd.draw_read) begin
                r_rd_vld <= r_tab_vld[slot_sel];
            end
        end
    end

    // Output register: drop the word when taken, load a new one on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.draw_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_finish) begin
            r_out <= diff[30:0];
        end
    end

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

>>> sv/combined_lcg_shuffle_rng.sv
// Combined two-modulus multiplicative congruential generator with a shuffle
// table. Each input word asks for one number: tuser = 0 draws the next value,
// tuser = 1 first reseeds from tdata (zero seed taken as one) and then draws.
// Every output word carries an integer in 1..2147483562; divide it by
// 2147483563 for a uniform deviate. The block takes one word at a time: a draw
// reads the shuffle slot and forms both products, writes back the generators,
// then combines, refills the slot and loads the result register once free. A
// reseed runs each of its TABLE_DEPTH + 8 chained warm-up and fill steps
// through the modular multiply. A finished word waits in the output register
// while the next input word is taken. The table starts out reading as zeros.
module combined_lcg_shuffle_rng #(
    parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seed_value, [31] zero
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [30:0] random_value, [31] zero
);

    clsr_pkg::t_cmd  cmd;
    clsr_pkg::t_stat stat;
    logic [clsr_pkg::VAL_W-1:0] out_data;

    clsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .i_stat   (stat),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd)
    );

    clsr_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_seed      (s_axis_tdata[30:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (out_data)
    );

    assign m_axis_tdata = {1'b0, out_data};

endmodule

>>> sv/clsr_checker.sv
module clsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // Output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Every number lies in 1..MAXOUT
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:0] != '0) && !m_axis_tdata[31]
                          && (m_axis_tdata[30:0] <= clsr_pkg::MAXOUT))
        else $error("output out of range");

    // One word at a time: ready drops after an accept
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // A plain draw into an empty output shows up without a stall, after S_DMUL and S_DFIN
    a_draw_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
        |-> ##3 m_axis_tvalid)
        else $error("draw result late");

    // Reset empties the output
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
